// File: rtl/core/morse_text_keyer_timing_unit_defines.svh
// assertion macros for the morse keyer timing unit
`ifndef MORSE_TEXT_KEYER_TIMING_UNIT_DEFINES_SVH
`define MORSE_TEXT_KEYER_TIMING_UNIT_DEFINES_SVH

`ifndef SYNTH

`define MKTT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define MKTT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define MKTT_ASSERT_SAME(label, clk, rst, ante, cons, msg)

`define MKTT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/core/mktt_pkg.sv
// types, constants and the morse pattern rom of the keyer timing unit
package mktt_pkg;

   typedef struct packed {
      logic [7:0] char_code;
      logic       new_text;
   } req_word_type;

   typedef struct packed {
      logic        key_down;
      logic [10:0] duration_ms;
      logic        last_of_run;
   } rsp_word_type;

   // csr register indexes
   localparam logic CSR_WPM    = 1'b0;
   localparam logic CSR_WEIGHT = 1'b1;

   localparam logic [6:0] WPM_RESET    = 7'd20;
   localparam logic [6:0] WPM_MIN      = 7'd5;
   localparam logic [6:0] WPM_MAX      = 7'd100;
   localparam logic [6:0] WEIGHT_RESET = 7'd50;
   localparam logic [6:0] WEIGHT_MIN   = 7'd10;
   localparam logic [6:0] WEIGHT_MAX   = 7'd90;
   localparam logic [6:0] PERCENT_FULL = 7'd100;

   // dit length numerator in ms
   localparam logic [10:0] DIT_NUMER   = 11'd1200;
   localparam int          DIV_STEPS   = 11;
   localparam logic [15:0] ROUND_HALF  = 16'd50;
   // floor(x/100) == (x*5243) >> 19 for x below 43690
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_DELTA = 8'h20;

   typedef enum logic [1:0] {
      EL_WORD_GAP = 2'd0,
      EL_CHAR_GAP = 2'd1,
      EL_MARK     = 2'd2,
      EL_INTRA    = 2'd3
   } elem_kind_type;

   // dah bits are left aligned: bit 5 is the first element
   typedef struct packed {
      logic       found;
      logic [2:0] len;
      logic [5:0] dah;
   } morse_code_type;

   typedef struct packed {
      logic          accept;
      logic          div_step;
      logic          mul;
      logic          scale;
      logic          set_prev;
      logic          clr_prev;
      logic          idx_clr;
      logic          idx_inc;
      logic          emit;
      elem_kind_type kind;
   } mktt_cmd_type;

   typedef struct packed {
      logic div_last;
      logic is_space;
      logic found;
      logic prev;
      logic last_elem;
      logic out_free;
   } mktt_status_type;

   function automatic morse_code_type mk_code(input logic [2:0] len, input logic [5:0] dah);
      morse_code_type r;
      r.found = 1'b1;
      r.len   = len;
      r.dah   = dah;
      return r;
   endfunction

   function automatic morse_code_type morse_lookup(input logic [7:0] c);
      morse_code_type r;
      r = '0;
      case (c)
         8'h41: r = mk_code(3'd2, 6'b010000); // A
         8'h42: r = mk_code(3'd4, 6'b100000); // B
         8'h43: r = mk_code(3'd4, 6'b101000); // C
         8'h44: r = mk_code(3'd3, 6'b100000); // D
         8'h45: r = mk_code(3'd1, 6'b000000); // E
         8'h46: r = mk_code(3'd4, 6'b001000); // F
         8'h47: r = mk_code(3'd3, 6'b110000); // G
         8'h48: r = mk_code(3'd4, 6'b000000); // H
         8'h49: r = mk_code(3'd2, 6'b000000); // I
         8'h4A: r = mk_code(3'd4, 6'b011100); // J
         8'h4B: r = mk_code(3'd3, 6'b101000); // K
         8'h4C: r = mk_code(3'd4, 6'b010000); // L
         8'h4D: r = mk_code(3'd2, 6'b110000); // M
         8'h4E: r = mk_code(3'd2, 6'b100000); // N
         8'h4F: r = mk_code(3'd3, 6'b111000); // O
         8'h50: r = mk_code(3'd4, 6'b011000); // P
         8'h51: r = mk_code(3'd4, 6'b110100); // Q
         8'h52: r = mk_code(3'd3, 6'b010000); // R
         8'h53: r = mk_code(3'd3, 6'b000000); // S
         8'h54: r = mk_code(3'd1, 6'b100000); // T
         8'h55: r = mk_code(3'd3, 6'b001000); // U
         8'h56: r = mk_code(3'd4, 6'b000100); // V
         8'h57: r = mk_code(3'd3, 6'b011000); // W
         8'h58: r = mk_code(3'd4, 6'b100100); // X
         8'h59: r = mk_code(3'd4, 6'b101100); // Y
         8'h5A: r = mk_code(3'd4, 6'b110000); // Z
         8'h30: r = mk_code(3'd5, 6'b111110); // 0
         8'h31: r = mk_code(3'd5, 6'b011110); // 1
         8'h32: r = mk_code(3'd5, 6'b001110); // 2
         8'h33: r = mk_code(3'd5, 6'b000110); // 3
         8'h34: r = mk_code(3'd5, 6'b000010); // 4
         8'h35: r = mk_code(3'd5, 6'b000000); // 5
         8'h36: r = mk_code(3'd5, 6'b100000); // 6
         8'h37: r = mk_code(3'd5, 6'b110000); // 7
         8'h38: r = mk_code(3'd5, 6'b111000); // 8
         8'h39: r = mk_code(3'd5, 6'b111100); // 9
         8'h2E: r = mk_code(3'd6, 6'b010101); // .
         8'h2C: r = mk_code(3'd6, 6'b110011); // ,
         8'h3F: r = mk_code(3'd6, 6'b001100); // ?
         8'h2F: r = mk_code(3'd5, 6'b100100); // /
         8'h3D: r = mk_code(3'd5, 6'b100010); // =
         8'h2B: r = mk_code(3'd5, 6'b010100); // +
         8'h2D: r = mk_code(3'd6, 6'b100001); // -
         8'h28: r = mk_code(3'd5, 6'b101100); // (
         8'h29: r = mk_code(3'd6, 6'b101101); // )
         8'h3A: r = mk_code(3'd6, 6'b111000); // :
         8'h3B: r = mk_code(3'd6, 6'b101010); // ;
         8'h27: r = mk_code(3'd6, 6'b011110); // apostrophe
         8'h22: r = mk_code(3'd6, 6'b010010); // double quote
         8'h40: r = mk_code(3'd6, 6'b011010); // @
         8'h21: r = mk_code(3'd6, 6'b101011); // !
         8'h26: r = mk_code(3'd5, 6'b010000); // &
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/core/mktt_ctrl.sv
// sequencer of the keyer timing unit: divide, scale, then element emission
module mktt_ctrl import mktt_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  mktt_status_type status,
   output mktt_cmd_type    cmd
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_DIV    = 9'b000000010,
      S_MUL    = 9'b000000100,
      S_SCALE  = 9'b000001000,
      S_DECIDE = 9'b000010000,
      S_WORD   = 9'b000100000,
      S_CGAP   = 9'b001000000,
      S_MARK   = 9'b010000000,
      S_INTRA  = 9'b100000000
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.kind  = EL_MARK;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_DECIDE;
         end
         S_DECIDE: begin
            if (status.is_space) begin
               state_in = status.prev ? S_WORD : S_IDLE;
            end else if (status.found) begin
               cmd.idx_clr  = 1'b1;
               cmd.set_prev = 1'b1;
               state_in     = status.prev ? S_CGAP : S_MARK;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_WORD: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.kind     = EL_WORD_GAP;
               cmd.clr_prev = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_CGAP: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EL_CHAR_GAP;
               state_in = S_MARK;
            end
         end
         S_MARK: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EL_MARK;
               state_in = status.last_elem ? S_IDLE : S_INTRA;
            end
         end
         S_INTRA: begin
            if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.kind    = EL_INTRA;
               cmd.idx_inc = 1'b1;
               state_in    = S_MARK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/mktt_datapath.sv
// datapath of the keyer timing unit: csr, lookup, serial divider, scaling, output word
module mktt_datapath import mktt_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  req_word_type    req_word,
   input  logic            csr_write,
   input  logic            csr_index,
   input  logic [6:0]      csr_data,
   input  logic            rsp_stall,
   output logic            rsp_valid,
   output rsp_word_type    rsp_word,
   input  mktt_cmd_type    cmd,
   output mktt_status_type status
);

   logic [6:0]   wpm_ff;
   logic [6:0]   weight_ff;
   logic         prev_ff;
   logic         prev_in;
   logic         space_ff;
   morse_code_type code_ff;
   logic [3:0]   cnt_ff;
   logic [6:0]   rem_ff;
   logic [7:0]   dit_ff;
   logic [15:0]  sum_mark_ff;
   logic [15:0]  sum_intra_ff;
   logic [8:0]   mark_ff;
   logic [8:0]   intra_ff;
   logic [2:0]   idx_ff;
   logic         rsp_valid_ff;
   rsp_word_type rsp_ff;
   rsp_word_type rsp_in;

   logic [6:0]   wpm_c;
   logic [6:0]   weight_c;
   logic [6:0]   space_pct;
   logic [7:0]   folded;
   logic         in_space;
   logic [7:0]   partial;
   logic         q_bit;
   logic [28:0]  scaled_mark;
   logic [28:0]  scaled_intra;
   logic [8:0]   mark_raw;
   logic [8:0]   intra_raw;
   logic [10:0]  dit_w;
   logic [10:0]  mark_w;
   logic         dah_now;

   // register values are clamped where they are used
   assign wpm_c = (wpm_ff < WPM_MIN) ? WPM_MIN : ((wpm_ff > WPM_MAX) ? WPM_MAX : wpm_ff);
   assign weight_c = (weight_ff < WEIGHT_MIN) ? WEIGHT_MIN :
                     ((weight_ff > WEIGHT_MAX) ? WEIGHT_MAX : weight_ff);
   assign space_pct = PERCENT_FULL - weight_c;

   assign folded = (req_word.char_code >= CH_LOWER_A && req_word.char_code <= CH_LOWER_Z) ?
                   req_word.char_code - CASE_DELTA : req_word.char_code;
   assign in_space = (folded == CH_SPACE) || (folded == CH_TAB) ||
                     (folded == CH_LF) || (folded == CH_CR);

   always_ff @(posedge clock) begin
      if (reset) begin
         wpm_ff    <= WPM_RESET;
         weight_ff <= WEIGHT_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_WPM) begin
            wpm_ff <= csr_data;
         end else begin
            weight_ff <= csr_data;
         end
      end
   end

   always_comb begin
      prev_in = prev_ff;
      if (cmd.accept && req_word.new_text) begin
         prev_in = 1'b0;
      end
      if (cmd.set_prev) begin
         prev_in = 1'b1;
      end
      if (cmd.clr_prev) begin
         prev_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= 1'b0;
      end else begin
         prev_ff <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         space_ff <= in_space;
         code_ff  <= morse_lookup(folded);
      end
   end

   // restoring divide of 1200 by the speed, one quotient bit a cycle
   assign partial = {rem_ff, DIT_NUMER[cnt_ff]};
   assign q_bit   = (partial >= {1'b0, wpm_c});

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cnt_ff <= 4'(DIV_STEPS - 1);
         rem_ff <= '0;
         dit_ff <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff - 4'd1;
         rem_ff <= q_bit ? 7'(partial - {1'b0, wpm_c}) : partial[6:0];
         dit_ff <= {dit_ff[6:0], q_bit};
      end
   end

   // 2*dit*pct + 50, then floor divide by 100 through the reciprocal
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         sum_mark_ff  <= {({7'd0, dit_ff} * {8'd0, weight_c}), 1'b0} + ROUND_HALF;
         sum_intra_ff <= {({7'd0, dit_ff} * {8'd0, space_pct}), 1'b0} + ROUND_HALF;
      end
   end

   assign scaled_mark  = sum_mark_ff * RECIP_100;
   assign scaled_intra = sum_intra_ff * RECIP_100;
   assign mark_raw     = scaled_mark[RECIP_SHIFT + 8:RECIP_SHIFT];
   assign intra_raw    = scaled_intra[RECIP_SHIFT + 8:RECIP_SHIFT];

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         mark_ff  <= (mark_raw == '0) ? 9'd1 : mark_raw;
         intra_ff <= (intra_raw == '0) ? 9'd1 : intra_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + 3'd1;
      end
   end

   assign dit_w   = {3'b000, dit_ff};
   assign mark_w  = {2'b00, mark_ff};
   assign dah_now = code_ff.dah[3'd5 - idx_ff];

   always_comb begin
      rsp_in = rsp_ff;
      case (cmd.kind)
         EL_WORD_GAP: begin
            rsp_in.key_down    = 1'b0;
            rsp_in.duration_ms = {dit_w[7:0], 3'b000} - dit_w;
            rsp_in.last_of_run = 1'b1;
         end
         EL_CHAR_GAP: begin
            rsp_in.key_down    = 1'b0;
            rsp_in.duration_ms = {dit_w[9:0], 1'b0} + dit_w;
            rsp_in.last_of_run = 1'b0;
         end
         EL_MARK: begin
            rsp_in.key_down    = 1'b1;
            rsp_in.duration_ms = dah_now ? ({mark_w[9:0], 1'b0} + mark_w) : mark_w;
            rsp_in.last_of_run = status.last_elem;
         end
         EL_INTRA: begin
            rsp_in.key_down    = 1'b0;
            rsp_in.duration_ms = {2'b00, intra_ff};
            rsp_in.last_of_run = 1'b0;
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase
   end

   // output word register, refilled in the cycle it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   assign status.div_last  = (cnt_ff == 4'd0);
   assign status.is_space  = space_ff;
   assign status.found     = code_ff.found;
   assign status.prev      = prev_ff;
   assign status.last_elem = (idx_ff == code_ff.len - 3'd1);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

endmodule

// File: rtl/core/morse_text_keyer_timing_unit.sv
// Morse keyer timing unit: one text byte in, up to twelve keying words out.
// Bytes are worked one at a time: a byte is accepted, the serial divider
// forms the dit as 1200 / speed, a multiply and a reciprocal scale form the
// weighted mark and space units, a decide step follows, then one keying word
// per cycle (up to 12) while the receiver does not stall. The output register
// lets the next word load in the cycle the current one is taken. Speed and
// weight are clamped to 5..100 and 10..90 when used; write them while idle.
module morse_text_keyer_timing_unit import mktt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [6:0]   csr_data
);

`include "morse_text_keyer_timing_unit_defines.svh"

   mktt_cmd_type    cmd;
   mktt_status_type status;

   assign csr_ready = 1'b1;

   mktt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mktt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .cmd       (cmd),
      .status    (status)
   );

   // a word is never loaded over one that is still waiting
   `MKTT_ASSERT_SAME(a_emit_free, clock, reset, cmd.emit, status.out_free, "emit over held word")

   // a byte is taken only one at a time
   `MKTT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "accepted while busy")

   // emission happens only after the byte has been fully worked out
   `MKTT_ASSERT_SAME(a_emit_idle, clock, reset, cmd.emit, req_stall && !cmd.div_step, "emit during setup")

endmodule

// File: tb/sv/morse_text_keyer_timing_unit_tb.sv
// self-checking testbench for the morse text keyer timing unit
module morse_text_keyer_timing_unit_tb import mktt_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int PHASES         = 7;
   localparam int BYTES_PER_SET  = 36;
   localparam int IDLE_WAIT      = 20;
   localparam int DRAIN_WAIT     = 40;
   localparam int LONG_HOLD_LEN  = 80;
   localparam logic [10:0] DIT_MS_NUMER = 11'd1200;

   // one stimulus row: typed rows carry their keying words, others use the predictor
   typedef struct packed {
      logic [7:0]   ch;
      logic         nt;
      logic         typed;
      logic [1:0]   n;
      rsp_word_type r0;
      rsp_word_type r1;
   } directed_row_type;

   localparam rsp_word_type NO_WORD = '0;

   // at reset speed 20 and weight 50: dit 60, dah 180, char gap 180, word gap 420
   localparam directed_row_type DIRECTED_ROWS [26] = '{
      '{"E",   1'b1, 1'b1, 2'd1, {1'b1, 11'd60, 1'b1}, NO_WORD},
      '{" ",   1'b0, 1'b1, 2'd1, {1'b0, 11'd420, 1'b1}, NO_WORD},
      '{" ",   1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
      '{"T",   1'b0, 1'b1, 2'd1, {1'b1, 11'd180, 1'b1}, NO_WORD},
      '{"e",   1'b0, 1'b1, 2'd2, {1'b0, 11'd180, 1'b0}, {1'b1, 11'd60, 1'b1}},
      '{8'h00, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
      '{8'hFF, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
      '{"a",   1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{"z",   1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{8'h09, 1'b0, 1'b1, 2'd1, {1'b0, 11'd420, 1'b1}, NO_WORD},
      '{8'h0A, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
      '{"0",   1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{8'h0D, 1'b0, 1'b1, 2'd1, {1'b0, 11'd420, 1'b1}, NO_WORD},
      '{".",   1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{",",   1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{"E",   1'b1, 1'b1, 2'd1, {1'b1, 11'd60, 1'b1}, NO_WORD},
      '{" ",   1'b1, 1'b1, 2'd0, NO_WORD, NO_WORD},
      '{"A",   1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{8'h80, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
      '{"Z",   1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{"9",   1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{"@",   1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{"&",   1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{8'h7B, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
      '{8'h60, 1'b1, 1'b1, 2'd0, NO_WORD, NO_WORD},
      '{"T",   1'b0, 1'b1, 2'd1, {1'b1, 11'd180, 1'b1}, NO_WORD}
   };

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_index = CSR_WPM;
   logic [6:0]   csr_data = '0;

   // predictor copy of the registers and the character flag
   logic [6:0]   speed_reg = WPM_RESET;
   logic [6:0]   weight_reg = WEIGHT_RESET;
   logic         after_char = 1'b0;

   rsp_word_type byte_elems [$];
   rsp_word_type keying_due [$];

   string morse_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?/=+-():;'\"@!&";
   string morse_pats [52] = '{
      ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
      "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
      "..-", "...-", ".--", "-..-", "-.--", "--..",
      "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
      "---..", "----.",
      ".-.-.-", "--..--", "..--..", "-..-.", "-...-", ".-.-.", "-....-", "-.--.",
      "-.--.-", "---...", "-.-.-.", ".----.", ".-..-.", ".--.-.", "-.-.--", ".-..."
   };

   bit gaps_on = 1'b1;
   bit long_hold = 1'b0;
   int stall_left = 0;
   int cycles = 0;
   int errors = 0;
   int checked = 0;
   int directed_bytes = 0;
   int random_bytes = 0;
   int keyed_bytes = 0;

   morse_text_keyer_timing_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("morse_text_keyer_timing_unit regression: fail");
         $finish;
      end
   end

   function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned lo,
                                             input int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned weighted_len(input int unsigned dit, input int unsigned pct);
      int unsigned u;
      u = (2 * dit * pct + 50) / 100;
      return (u < 1) ? 1 : u;
   endfunction

   function automatic void add_elem(input logic key, input int unsigned dur);
      rsp_word_type e;
      e.key_down    = key;
      e.duration_ms = dur[10:0];
      e.last_of_run = 1'b0;
      byte_elems = {byte_elems, e};
   endfunction

   // keying words caused by one text byte, advances the character flag
   function automatic void key_byte(input req_word_type w);
      logic [7:0]  c;
      int unsigned spd, wt, dit, mark, intra;
      int          idx, i;
      string       pat;
      byte_elems.delete();
      spd   = clamp_reg(speed_reg, WPM_MIN, WPM_MAX);
      wt    = clamp_reg(weight_reg, WEIGHT_MIN, WEIGHT_MAX);
      dit   = DIT_MS_NUMER / spd;
      mark  = weighted_len(dit, wt);
      intra = weighted_len(dit, PERCENT_FULL - wt);
      if (w.new_text) after_char = 1'b0;
      c = w.char_code;
      if (c >= CH_LOWER_A && c <= CH_LOWER_Z) c = c - CASE_DELTA;
      if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
         if (after_char) begin
            add_elem(1'b0, 7 * dit);
            after_char = 1'b0;
         end
      end else begin
         idx = -1;
         for (i = 0; i < 52; i++)
            if (morse_chars[i] == c) idx = i;
         if (idx >= 0) begin
            pat = morse_pats[idx];
            if (after_char) add_elem(1'b0, 3 * dit);
            for (i = 0; i < pat.len(); i++) begin
               if (i > 0) add_elem(1'b0, intra);
               add_elem(1'b1, (pat[i] == "-") ? 3 * mark : mark);
            end
            after_char = 1'b1;
         end
      end
      if (byte_elems.size() > 0) byte_elems[byte_elems.size() - 1].last_of_run = 1'b1;
   endfunction

   function automatic void take_keying_word(input rsp_word_type got);
      rsp_word_type want;
      checked++;
      if (keying_due.size() == 0) begin
         $display("%0t: unexpected keying word, expected none, got %h", $time, got);
         errors++;
      end else begin
         want = keying_due.pop_front();
         if (got.key_down !== want.key_down) begin
            $display("%0t: key_down expected %0d, got %0d", $time, want.key_down,
                     got.key_down);
            errors++;
         end
         if (got.duration_ms !== want.duration_ms) begin
            $display("%0t: duration_ms expected %0d, got %0d", $time, want.duration_ms,
                     got.duration_ms);
            errors++;
         end
         if (got.last_of_run !== want.last_of_run) begin
            $display("%0t: last_of_run expected %0d, got %0d", $time, want.last_of_run,
                     got.last_of_run);
            errors++;
         end
      end
   endfunction

   task automatic send_byte(input req_word_type w, input directed_row_type row, output int n);
      int i;
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      key_byte(w);
      n = byte_elems.size();
      if (row.typed) begin
         byte_elems.delete();
         if (row.n > 0) byte_elems = {byte_elems, row.r0};
         if (row.n > 1) byte_elems = {byte_elems, row.r1};
      end
      for (i = 0; i < byte_elems.size(); i++) keying_due = {keying_due, byte_elems[i]};
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic set_speed_weight(input logic [6:0] spd, input logic [6:0] wt);
      csr_valid <= 1'b1;
      csr_index <= CSR_WPM;
      csr_data  <= spd;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_WEIGHT;
      csr_data  <= wt;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      speed_reg  = spd;
      weight_reg = wt;
   endtask

   task automatic wait_idle();
      while (keying_due.size() != 0) @(posedge clock);
      // a byte with no keying words may still be in the divider
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   // mostly real text with random content, some raw noise bytes
   function automatic req_word_type pick_text_byte();
      req_word_type w;
      int           r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         w.char_code = morse_chars[$urandom_range(0, 51)];
         if (w.char_code >= "A" && w.char_code <= "Z" && $urandom_range(0, 1))
            w.char_code = w.char_code + CASE_DELTA;
      end else if (r < 84) begin
         case ($urandom_range(0, 3))
            0: w.char_code = CH_TAB;
            1: w.char_code = CH_LF;
            2: w.char_code = CH_CR;
            default: w.char_code = CH_SPACE;
         endcase
      end else begin
         w.char_code = 8'($urandom_range(0, 255));
      end
      w.new_text = ($urandom_range(0, 15) == 0);
      return w;
   endfunction

   // receiver: checks each taken word, stalls in bursts and once for a long stretch
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) take_keying_word(rsp_word);
         if (stall_left > 0) begin
            stall_left--;
         end else if (long_hold) begin
            stall_left = LONG_HOLD_LEN;
            long_hold  = 1'b0;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 5);
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   initial begin
      req_word_type w;
      int           i, n, phase, counted;
      logic [6:0]   spd, wt;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < $size(DIRECTED_ROWS); i++) begin
         w.char_code = DIRECTED_ROWS[i].ch;
         w.new_text  = DIRECTED_ROWS[i].nt;
         send_byte(w, DIRECTED_ROWS[i], n);
         directed_bytes++;
      end
      req_valid <= 1'b0;

      for (phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: begin spd = 7'd0;   wt = 7'd0;   end
            1: begin spd = 7'd127; wt = 7'd127; end
            2: begin spd = WPM_MIN; wt = WEIGHT_MAX; end
            3: begin spd = WPM_MAX; wt = WEIGHT_MIN; end
            default: begin
               spd = 7'($urandom_range(0, 127));
               wt  = 7'($urandom_range(0, 127));
            end
         endcase
         set_speed_weight(spd, wt);
         if (phase == 1) long_hold = 1'b1;
         // last setting runs with both sides at full rate
         if (phase == PHASES - 1) gaps_on = 1'b0;
         counted = 0;
         for (i = 0; i < BYTES_PER_SET; i++) begin
            send_byte(pick_text_byte(), '0, n);
            if (n > 0) counted++;
         end
         random_bytes += BYTES_PER_SET;
         keyed_bytes  += counted;
         req_valid <= 1'b0;
      end

      while (keying_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("sent %0d table bytes and %0d random bytes (%0d keyed) over %0d settings",
               directed_bytes, random_bytes, keyed_bytes, PHASES + 1);
      $display("checked %0d keying words, %0d mismatches", checked, errors);
      if (errors == 0 && keying_due.size() == 0)
         $display("morse_text_keyer_timing_unit regression: pass");
      else
         $display("morse_text_keyer_timing_unit regression: fail");
      $finish;
   end

endmodule
